// ===== hw/rtl/trapezoidal_motion_profile_unit_assert.svh =====
// assertion macros shared by the motion profile rtl
`ifndef TRAPEZOIDAL_MOTION_PROFILE_UNIT_ASSERT_SVH
`define TRAPEZOIDAL_MOTION_PROFILE_UNIT_ASSERT_SVH

// same-cycle implication on clk_i, off during reset
`define TMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off during reset
`define TMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tmp_pkg.sv =====
`default_nettype none

package tmp_pkg;

  localparam int unsigned POS_W    = 48;
  localparam int unsigned VEL_W    = 32;
  localparam int unsigned DT_W     = 16;
  localparam int unsigned ACC_W    = 24;
  localparam int unsigned LIM_W    = 31;
  localparam int unsigned DIV_W    = ACC_W + 1;
  localparam int unsigned MUL_W    = 31;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned STEP_W   = ACC_W + DT_W - 4;
  localparam int unsigned SPLIT_W  = 23;
  localparam int unsigned DIFF_W   = POS_W + 1;
  localparam int unsigned VSUM_W   = STEP_W + 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_TDATA_W  = DT_W + POS_W + VEL_W;
  localparam int unsigned OUT_TDATA_W = POS_W + VEL_W;

  localparam logic [ACC_W-1:0] ACC_RESET = 24'd1000;
  localparam logic [LIM_W-1:0] LIM_RESET = 31'd65536000;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL = 1'b0,
    CFG_SPEED = 1'b1
  } cfg_idx_e;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_STEP = 11'b000_0000_0010,
    ST_SQ   = 11'b000_0000_0100,
    ST_PA   = 11'b000_0000_1000,
    ST_PB   = 11'b000_0001_0000,
    ST_CMP  = 11'b000_0010_0000,
    ST_VEL  = 11'b000_0100_0000,
    ST_ABS  = 11'b000_1000_0000,
    ST_DX   = 11'b001_0000_0000,
    ST_POS  = 11'b010_0000_0000,
    ST_FIN  = 11'b100_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    MS_ACC_DT = 3'd0,
    MS_V_SQ   = 3'd1,
    MS_AD_HI  = 3'd2,
    MS_AD_LO  = 3'd3,
    MS_V_DT   = 3'd4
  } mul_sel_e;

  typedef struct packed {
    state_e   st;
    mul_sel_e mul_sel;
    logic     take;
    logic     fin_load;
    logic     in_ready;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tmp_mul.sv =====
`default_nettype none

module tmp_mul (
  input  logic                       clk_i,
  input  logic [tmp_pkg::MUL_W-1:0]  a_i,
  input  logic [tmp_pkg::MUL_W-1:0]  b_i,
  output logic [tmp_pkg::PROD_W-1:0] p_o
);
  import tmp_pkg::*;

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tmp_seq.sv =====
`default_nettype none
`include "trapezoidal_motion_profile_unit_assert.svh"

module tmp_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           dt_zero_i,
  input  logic           vmode_i,
  input  logic           out_free_i,
  output tmp_pkg::ctrl_t ctrl_o
);
  import tmp_pkg::*;

  state_e st_q, st_d;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          st_d = dt_zero_i ? ST_FIN : ST_STEP;
        end
      end
      ST_STEP: st_d = ST_SQ;
      ST_SQ:   st_d = vmode_i ? ST_CMP : ST_PA;
      ST_PA:   st_d = ST_PB;
      ST_PB:   st_d = ST_CMP;
      ST_CMP:  st_d = ST_VEL;
      ST_VEL:  st_d = ST_ABS;
      ST_ABS:  st_d = ST_DX;
      ST_DX:   st_d = ST_POS;
      ST_POS:  st_d = ST_FIN;
      ST_FIN: begin
        if (out_free_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    ctrl_o.st       = st_q;
    ctrl_o.in_ready = (st_q == ST_IDLE);
    ctrl_o.take     = (st_q == ST_IDLE) && in_valid_i;
    ctrl_o.fin_load = (st_q == ST_FIN) && out_free_i;
    case (st_q)
      ST_SQ:   ctrl_o.mul_sel = MS_V_SQ;
      ST_PA:   ctrl_o.mul_sel = MS_AD_HI;
      ST_PB:   ctrl_o.mul_sel = MS_AD_LO;
      ST_DX:   ctrl_o.mul_sel = MS_V_DT;
      default: ctrl_o.mul_sel = MS_ACC_DT;
    endcase
  end

  `TMP_ASSERT_NXT(a_vmode_skips_split, (st_q == ST_SQ) && vmode_i, st_q == ST_CMP, "velocity mode entered the stop test")
  `TMP_ASSERT_NXT(a_fin_returns_idle, (st_q == ST_FIN) && out_free_i, st_q == ST_IDLE, "result load did not end the tick")

endmodule

`default_nettype wire

// ===== hw/rtl/trapezoidal_motion_profile_unit.sv =====
// sequence: a tick runs from the input transfer through STEP, SQ, PA and PB (position mode only), CMP, VEL,
//   ABS, DX, POS and FIN, where the result loads into the output register once that register is free; a zero
//   time step goes straight to FIN. A new tick is taken only in IDLE, after the last result has loaded, as the
//   states pass in turn through the single shared 31x31 multiplier
// reset: position and velocity clear to zero, accel_limit 1000, speed_limit 65536000
`default_nettype none
`include "trapezoidal_motion_profile_unit_assert.svh"

module trapezoidal_motion_profile_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tmp_pkg::LIM_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // time_step, target_position, cruise_speed
  input  logic [tmp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // velocity_mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // position_out, velocity_out
  output logic [tmp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // arrived
  output logic                            m_axis_tuser
);
  import tmp_pkg::*;

  ctrl_t ctrl;

  logic [ACC_W-1:0] accel_q;
  logic [LIM_W-1:0] lim_q;

  logic signed [POS_W-1:0] pos_q;
  logic signed [VEL_W-1:0] vel_q;

  logic [DT_W-1:0]         dt_q;
  logic signed [POS_W-1:0] tgt_q;
  logic signed [VEL_W-1:0] cru_q;
  logic                    vm_q;
  logic                    dtz_q;

  logic signed [DIFF_W-1:0] d_q;
  logic [DIFF_W-1:0]        ad_q;
  logic [MUL_W-1:0]         av_q;
  logic [STEP_W-1:0]        step_q;
  logic [PROD_W-1:0]        sq_q;
  logic [POS_W-1:0]         hi_q;
  logic                     close_q;
  logic                     neg_q;
  logic signed [VEL_W-1:0]  vnew_q;
  logic [MUL_W-1:0]         vabs_q;
  logic signed [DIFF_W-1:0] next_q;

  logic                    out_valid_q;
  logic signed [POS_W-1:0] out_pos_q;
  logic signed [VEL_W-1:0] out_vel_q;
  logic                    out_arr_q;
  logic                    out_free;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  div;

  assign out_free = !out_valid_q || m_axis_tready;

  tmp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .dt_zero_i  (s_axis_tdata[DT_W-1:0] == '0),
    .vmode_i    (vm_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign s_axis_tready = ctrl.in_ready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= ACC_RESET;
      lim_q   <= LIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACCEL: accel_q <= cfg_data_i[ACC_W-1:0];
        CFG_SPEED: lim_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  assign div = {((accel_q == '0) ? ACC_W'(1) : accel_q), 1'b0};

  always_comb begin
    case (ctrl.mul_sel)
      MS_V_SQ: begin
        mul_a = av_q;
        mul_b = av_q;
      end
      MS_AD_HI: begin
        mul_a = MUL_W'(ad_q[2*SPLIT_W-1:SPLIT_W]);
        mul_b = MUL_W'(div);
      end
      MS_AD_LO: begin
        mul_a = MUL_W'(ad_q[SPLIT_W-1:0]);
        mul_b = MUL_W'(div);
      end
      MS_V_DT: begin
        mul_a = vabs_q;
        mul_b = MUL_W'(dt_q);
      end
      default: begin
        mul_a = MUL_W'(accel_q);
        mul_b = MUL_W'(dt_q);
      end
    endcase
  end

  tmp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // datapath arithmetic per step
  logic [VEL_W-1:0]          vel_abs;
  logic signed [DIFF_W-1:0]  d_c;
  logic [DIFF_W-1:0]         ad_c;
  logic [POS_W+SPLIT_W-1:0]  prod_ad;
  logic                      near;
  logic signed [VEL_W:0]     dv;
  logic [VEL_W:0]            adv;
  logic                      dzero, d_neg, d_pos, v_neg, v_pos, opposing, brake;
  logic                      close_c, neg_c;
  logic signed [VSUM_W-1:0]  vel_x, step_x, cru_x, lim_x, vsum;
  logic signed [VEL_W-1:0]   vnew_c;
  logic [VEL_W-1:0]          vnew_abs;
  logic [MUL_W+DT_W-21:0]    mag;
  logic signed [DIFF_W-1:0]  pos_x, mag_x, next_c;
  logic signed [DIFF_W:0]    dn;
  logic                      snap;
  logic signed [POS_W-1:0]   next_sat, pos_new;
  logic signed [VEL_W-1:0]   vel_new;
  logic                      arr_new;

  always_comb begin
    vel_abs = vel_q[VEL_W-1] ? VEL_W'(-vel_q) : VEL_W'(vel_q);
    d_c     = $signed({tgt_q[POS_W-1], tgt_q}) - $signed({pos_q[POS_W-1], pos_q});
    ad_c    = d_q[DIFF_W-1] ? DIFF_W'(-d_q) : DIFF_W'(d_q);

    // stop test: |d| * 2a <= (v*v) >> 16
    prod_ad = {hi_q, {SPLIT_W{1'b0}}} + (POS_W+SPLIT_W)'(prod[POS_W-1:0]);
    near    = (ad_q[DIFF_W-1:2*SPLIT_W] == '0)
           && (prod_ad[POS_W+SPLIT_W-1:PROD_W-16] == '0)
           && (prod_ad[PROD_W-17:0] <= sq_q[PROD_W-1:16]);

    dv      = $signed({cru_q[VEL_W-1], cru_q}) - $signed({vel_q[VEL_W-1], vel_q});
    adv     = dv[VEL_W] ? (VEL_W+1)'(-dv) : (VEL_W+1)'(dv);
    close_c = vm_q && (STEP_W'(adv) <= step_q);

    dzero    = (d_q == '0);
    d_neg    = d_q[DIFF_W-1];
    d_pos    = !d_neg && !dzero;
    v_neg    = vel_q[VEL_W-1];
    v_pos    = !v_neg && (vel_q != '0);
    opposing = (d_pos && v_neg) || (d_neg && v_pos);
    brake    = !opposing && near;
    neg_c    = vm_q ? dv[VEL_W] : (brake ? d_pos : d_neg);

    vel_x  = VSUM_W'(vel_q);
    cru_x  = VSUM_W'(cru_q);
    step_x = $signed({2'b00, step_q});
    lim_x  = $signed({{(VSUM_W-LIM_W){1'b0}}, lim_q});
    vsum   = close_q ? cru_x : (neg_q ? (vel_x - step_x) : (vel_x + step_x));
    if (vsum > lim_x) begin
      vnew_c = VEL_W'(lim_x);
    end else if (vsum < -lim_x) begin
      vnew_c = VEL_W'(-lim_x);
    end else begin
      vnew_c = vsum[VEL_W-1:0];
    end

    vnew_abs = vnew_q[VEL_W-1] ? VEL_W'(-vnew_q) : VEL_W'(vnew_q);

    // truncation toward zero of v * dt / 2^20
    mag    = prod[MUL_W+DT_W-1:20];
    pos_x  = DIFF_W'(pos_q);
    mag_x  = $signed(DIFF_W'(mag));
    next_c = vnew_q[VEL_W-1] ? (pos_x - mag_x) : (pos_x + mag_x);

    dn       = $signed({{2{tgt_q[POS_W-1]}}, tgt_q}) - $signed({next_q[DIFF_W-1], next_q});
    snap     = !vm_q && (dzero || (dn == '0) || (d_q[DIFF_W-1] != dn[DIFF_W]));
    next_sat = (next_q[DIFF_W-1] != next_q[POS_W-1])
             ? (next_q[DIFF_W-1] ? POS_MIN : POS_MAX) : next_q[POS_W-1:0];

    if (dtz_q) begin
      pos_new = pos_q;
      vel_new = vel_q;
      arr_new = 1'b0;
    end else if (snap) begin
      pos_new = tgt_q;
      vel_new = '0;
      arr_new = 1'b1;
    end else begin
      pos_new = next_sat;
      vel_new = vnew_q;
      arr_new = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.take) begin
      dt_q  <= s_axis_tdata[DT_W-1:0];
      tgt_q <= s_axis_tdata[DT_W+POS_W-1:DT_W];
      cru_q <= s_axis_tdata[IN_TDATA_W-1:DT_W+POS_W];
      vm_q  <= s_axis_tuser;
      dtz_q <= (s_axis_tdata[DT_W-1:0] == '0);
    end
    case (ctrl.st)
      ST_STEP: begin
        d_q  <= d_c;
        av_q <= vel_abs[MUL_W-1:0];
      end
      ST_SQ: begin
        step_q <= prod[STEP_W+3:4];
        ad_q   <= ad_c;
      end
      ST_PA:  sq_q   <= prod;
      ST_PB:  hi_q   <= prod[POS_W-1:0];
      ST_CMP: begin
        close_q <= close_c;
        neg_q   <= neg_c;
      end
      ST_VEL: vnew_q <= vnew_c;
      ST_ABS: vabs_q <= vnew_abs[MUL_W-1:0];
      ST_POS: next_q <= next_c;
      default: ;
    endcase
    if (ctrl.fin_load) begin
      out_pos_q <= pos_new;
      out_vel_q <= vel_new;
      out_arr_q <= arr_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.fin_load) begin
        pos_q       <= pos_new;
        vel_q       <= vel_new;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_vel_q, out_pos_q};
  assign m_axis_tuser  = out_arr_q;

  `TMP_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a tick is in work")
  `TMP_ASSERT_IMP(a_arrived_at_rest, out_valid_q && out_arr_q, out_vel_q == '0, "arrival reported with nonzero velocity")
  `TMP_ASSERT_IMP(a_state_matches_out, out_valid_q && (ctrl.st == ST_IDLE), (pos_q == out_pos_q) && (vel_q == out_vel_q), "held state differs from reported state")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  import tmp_pkg::*;

  localparam int TOTAL_TICKS = 2000;
  localparam int CALM_TICKS = 300;
  localparam int PHASE_TICKS = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam longint PMAX = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint PMIN = -PMAX - 1;

  typedef struct packed {
    logic                    vmode;
    logic signed [VEL_W-1:0] cruise;
    logic signed [POS_W-1:0] target;
    logic [DT_W-1:0]         dt;
  } tick_t;

  typedef struct packed {
    logic                    arrived;
    logic signed [VEL_W-1:0] vel;
    logic signed [POS_W-1:0] pos;
  } motion_t;

  typedef struct packed {
    logic    aim_here;
    logic    known;
    motion_t want;
    tick_t   t;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [LIM_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  // predictor state and limits
  longint cur_pos = 0;
  longint cur_vel = 0;
  longint accel_lim = 1000;
  longint speed_lim = 65536000;

  motion_t pending_motion[$];
  motion_t head;
  plan_row_t plan[$];
  int fails = 0;
  int sent = 0;
  int checked = 0;
  int arrivals = 0;
  int phases = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit bursts_on = 1'b1;

  trapezoidal_motion_profile_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int sign_of(longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic longint clamp_pos(longint p);
    if (p > PMAX) return PMAX;
    if (p < PMIN) return PMIN;
    return p;
  endfunction

  function automatic longint clamp_vel(longint v);
    if (v > speed_lim) return speed_lim;
    if (v < -speed_lim) return -speed_lim;
    return v;
  endfunction

  function automatic motion_t advance_profile(tick_t t);
    longint tgt, cru, dtl, step, v, dv, adv, d, nxt, dn;
    longint unsigned av, ad, dvsr, stop;
    int dir;
    motion_t r;
    tgt = longint'(t.target);
    cru = longint'(t.cruise);
    dtl = longint'(t.dt);
    r.arrived = 1'b0;
    if (dtl != 0) begin
      step = (accel_lim * dtl) >>> 4;
      v = cur_vel;
      if (t.vmode) begin
        dv = cru - v;
        adv = (dv < 0) ? -dv : dv;
        if (adv <= step) v = cru;
        else v = v + ((dv > 0) ? step : -step);
        v = clamp_vel(v);
        cur_vel = v;
        cur_pos = clamp_pos(cur_pos + (v * dtl) / 1048576);
      end else begin
        d = tgt - cur_pos;
        if (d == 0 && v == 0) begin
          cur_pos = tgt;
          cur_vel = 0;
          r.arrived = 1'b1;
        end else begin
          av = (v < 0) ? -v : v;
          ad = (d < 0) ? -d : d;
          dvsr = 2 * ((accel_lim == 0) ? 1 : accel_lim);
          stop = (av * av / dvsr) >> 16;
          if ((d > 0 && v < 0) || (d < 0 && v > 0)) dir = -sign_of(v);
          else if (ad <= stop) dir = -sign_of(d);
          else dir = sign_of(d);
          v = clamp_vel(v + dir * step);
          nxt = cur_pos + (v * dtl) / 1048576;
          dn = tgt - nxt;
          if (d == 0 || dn == 0 || sign_of(d) != sign_of(dn)) begin
            cur_pos = tgt;
            cur_vel = 0;
            r.arrived = 1'b1;
          end else begin
            cur_pos = clamp_pos(nxt);
            cur_vel = v;
          end
        end
      end
    end
    r.pos = cur_pos[POS_W-1:0];
    r.vel = cur_vel[VEL_W-1:0];
    return r;
  endfunction

  function automatic longint rand_span(int unsigned bits);
    longint r;
    r = longint'({$urandom, $urandom}) & ((longint'(1) <<< bits) - 1);
    return ($urandom_range(0, 1) != 0) ? -r : r;
  endfunction

  function automatic plan_row_t mk_row(logic [DT_W-1:0] dt, logic signed [POS_W-1:0] tgt,
                                       logic signed [VEL_W-1:0] cru, logic vm, logic aim,
                                       logic known, longint epos, longint evel, logic earr);
    plan_row_t row;
    row.t.dt = dt;
    row.t.target = tgt;
    row.t.cruise = cru;
    row.t.vmode = vm;
    row.aim_here = aim;
    row.known = known;
    row.want.pos = epos[POS_W-1:0];
    row.want.vel = evel[VEL_W-1:0];
    row.want.arrived = earr;
    return row;
  endfunction

  task automatic send_tick(tick_t t, logic known, motion_t want);
    motion_t got;
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {t.cruise, t.target, t.dt};
    s_axis_tuser <= t.vmode;
    do @(posedge clk_i); while (!s_axis_tready);
    got = advance_profile(t);
    pending_motion.push_back(known ? want : got);
    sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [ACC_W-1:0] acc, logic [LIM_W-1:0] spd);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ACCEL;
    cfg_data_i <= LIM_W'(acc);
    @(posedge clk_i);
    cfg_idx_i <= CFG_SPEED;
    cfg_data_i <= spd;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    accel_lim = longint'(acc);
    speed_lim = longint'(spd);
    phases++;
  endtask

  // result side: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_motion.size() == 0) begin
        $error("result transfer with nothing expected");
        fails++;
      end else begin
        head = pending_motion.pop_front();
        checked++;
        if (m_axis_tuser) arrivals++;
        if (m_axis_tdata[POS_W-1:0] !== head.pos) begin
          $error("position_out: expected %0d, got %0d", head.pos,
                 $signed(m_axis_tdata[POS_W-1:0]));
          fails++;
        end
        if (m_axis_tdata[POS_W +: VEL_W] !== head.vel) begin
          $error("velocity_out: expected %0d, got %0d", head.vel,
                 $signed(m_axis_tdata[POS_W +: VEL_W]));
          fails++;
        end
        if (m_axis_tuser !== head.arrived) begin
          $error("arrived: expected %0b, got %0b", head.arrived, m_axis_tuser);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("trapezoidal_motion_profile_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    tick_t t;
    motion_t none;
    logic [ACC_W-1:0] acc;
    logic [LIM_W-1:0] spd;
    logic run_vmode;
    logic [DT_W-1:0] run_dt;
    logic signed [POS_W-1:0] run_target;
    logic signed [VEL_W-1:0] run_cruise;
    int run_len, roll, phase_end;
    none = '0;

    // zero time step, rest on target, full-scale cruise and targets, zero distance while moving
    plan.push_back(mk_row(16'h0000, 48'sd1, 32'sd0, 1'b0, 1'b0, 1'b1, 0, 0, 1'b0));
    plan.push_back(mk_row(16'h0001, 48'sd0, 32'sd0, 1'b0, 1'b0, 1'b1, 0, 0, 1'b1));
    plan.push_back(mk_row(16'hFFFF, 48'sd0, 32'h7FFFFFFF, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, 48'sd0, 32'h7FFFFFFF, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'h0000, 48'sd0, 32'h55555555, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'h0001, 48'sd0, 32'h80000000, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, 48'sd0, 32'h80000000, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'h012C, 48'sd0, 32'hAAAAAAAA, 1'b0, 1'b1, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, POS_MAX, 32'sd0, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, POS_MAX, 32'sd0, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, POS_MIN, 32'sd0, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, POS_MIN, 32'sd0, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'h0001, 48'h555555555555, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b0,
                          0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, 48'hAAAAAAAAAAAA, 32'sd0, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, 48'sd0, 32'sd0, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, 48'sd0, 32'sd0, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, 48'sd0, 32'sd0, 1'b0, 1'b1, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'h0001, 48'sd0, 32'sd0, 1'b0, 1'b1, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, 48'sd10, 32'sd0, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0));
    plan.push_back(mk_row(16'hFFFF, 48'sd10, 32'sd0, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      t = plan[i].t;
      if (plan[i].aim_here) t.target = cur_pos[POS_W-1:0];
      send_tick(t, plan[i].known, plan[i].want);
    end

    while (sent < TOTAL_TICKS) begin
      drain();
      case (phases)
        0: begin acc = 24'd1; spd = 31'h7FFFFFFF; end
        1: begin acc = 24'hFFFFFF; spd = 31'd0; end
        2: begin acc = 24'hFFFFFF; spd = 31'h7FFFFFFF; end
        3: begin acc = 24'd1000; spd = 31'd65536000; end
        default: begin
          acc = ACC_W'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20));
          if (acc == 0) acc = 24'd1;
          spd = LIM_W'($urandom_range(0, 31'h7FFFFFFF) >> $urandom_range(0, 16));
        end
      endcase
      set_limits(acc, spd);
      phase_end = sent + PHASE_TICKS;
      while (sent < phase_end && sent < TOTAL_TICKS) begin
        run_vmode = ($urandom_range(0, 3) == 0);
        run_dt = ($urandom_range(0, 3) == 0) ? DT_W'($urandom_range(1, 16'hFFFF))
                                              : DT_W'($urandom_range(1, 8192));
        run_len = $urandom_range(4, 60);
        if ($urandom_range(0, 7) == 0) run_target = POS_W'({$urandom, $urandom});
        else run_target = POS_W'(clamp_pos(cur_pos + rand_span($urandom_range(0, 40))));
        if ($urandom_range(0, 3) == 0) run_cruise = $urandom;
        else run_cruise = VEL_W'(rand_span($urandom_range(0, 31)));
        for (int k = 0; k < run_len && sent < phase_end && sent < TOTAL_TICKS; k++) begin
          bursts_on = (sent < TOTAL_TICKS - CALM_TICKS);
          t.dt = run_dt;
          t.vmode = run_vmode;
          t.target = run_vmode ? POS_W'({$urandom, $urandom}) : run_target;
          t.cruise = run_vmode ? run_cruise : $urandom;
          roll = $urandom_range(0, 99);
          if (roll < 4) t.dt = '0;
          else if (roll < 8) t.dt = DT_W'($urandom);
          else if (roll < 11) t.vmode = ~t.vmode;
          else if (roll < 14) t.target = cur_pos[POS_W-1:0];
          send_tick(t, 1'b0, none);
        end
      end
    end

    drain();
    $display("%0d ticks in %0d limit settings after the directed rows", sent, phases);
    $display("%0d results checked, %0d of them arrivals on target", checked, arrivals);
    if (fails == 0 && pending_motion.size() == 0) begin
      $display("trapezoidal_motion_profile_unit: match");
    end else begin
      $display("trapezoidal_motion_profile_unit: mismatch");
    end
    $finish;
  end

endmodule
